// ===== design/ptw_pkg.sv =====
package ptw_pkg;

    localparam int ENTRY_W   = 42;
    localparam int FRAME_W   = 40;
    localparam int IDX_W     = 9;
    localparam int OFFSET_W  = 12;
    localparam int VA_W      = 48;
    localparam int PA_W      = 52;
    localparam int IN_DATA_W = 104;
    localparam int OUT_DATA_W = 56;

    localparam int ENTRY_PRESENT_BIT  = 0;
    localparam int ENTRY_WRITABLE_BIT = 1;

    localparam logic [1:0] CMD_MAP       = 2'd0;
    localparam logic [1:0] CMD_UNMAP     = 2'd1;
    localparam logic [1:0] CMD_TRANSLATE = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NOT_MAPPED = 2'd1;
    localparam logic [1:0] STATUS_ALREADY    = 2'd2;
    localparam logic [1:0] STATUS_NO_TABLES  = 2'd3;

    localparam logic [1:0] LEVEL_LEAF = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } walk_state_t;

endpackage

// ===== design/four_level_page_table_walker_unit.sv =====
// four-level page table walker
// input channel s_*: one command per transaction (map, unmap, translate) with
// virtual address, physical address and writable flag; output channel m_*:
// one result per command (translated address, status, leaf writable flag)
// after reset the table store is swept to zero, one entry per cycle, over
// all TABLE_COUNT*512 entries; s_tready stays low until the sweep is done
// each walk level takes a read, then an evaluate step that may write back,
// on the single table store port; a full command walks all four levels, a
// walk can stop early at level k (0..2), and unused command code three goes
// straight to the result without a walk
// one command is in work at a time, so no new command is accepted until the
// walk before it is done; the next command is accepted as soon as the
// walker is back in idle, even while the previous result still waits in
// the output register
// when the receiver stalls, a finished walk holds its result until the
// output register drains, and no new command is taken in the meantime
// table numbers are handed out from a pool that only grows; table 0 is root
module four_level_page_table_walker_unit #(
    parameter int TABLE_COUNT = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // command[1:0], virt_addr[49:2], map_addr[101:50], writable[102]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata   // result_addr[51:0], status[53:52], leaf_writable[54]
);

    localparam int TW    = $clog2(TABLE_COUNT);
    localparam int NW    = $clog2(TABLE_COUNT + 1);
    localparam int DEPTH = TABLE_COUNT * 512;
    localparam int AW    = $clog2(DEPTH);

    ptw_pkg::walk_state_t state_reg, state_next;

    logic [AW-1:0]                clr_reg, clr_next;
    logic [1:0]                   lvl_reg, lvl_next;
    logic [TW-1:0]                table_reg, table_next;
    logic [NW-1:0]                free_reg, free_next;
    logic [1:0]                   cmd_reg, cmd_next;
    logic [ptw_pkg::VA_W-1:0]     va_reg, va_next;
    logic [ptw_pkg::FRAME_W-1:0]  frame_reg, frame_next;
    logic                         wr_reg, wr_next;
    logic [ptw_pkg::PA_W-1:0]     res_addr_reg, res_addr_next;
    logic [1:0]                   res_status_reg, res_status_next;
    logic                         res_lw_reg, res_lw_next;
    logic                         m_valid_reg, m_valid_next;
    logic [ptw_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                          ram_en;
    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [ptw_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [ptw_pkg::ENTRY_W-1:0]   ram_rdata;

    logic [ptw_pkg::IDX_W-1:0]     idx;
    logic                          in_accept;
    logic                          out_free;
    logic                          ent_present;
    logic [ptw_pkg::FRAME_W-1:0]   ent_num;
    logic                          num_ok;
    logic                          pool_empty;
    logic                          walk_stop;

    ptw_ram #(
        .WIDTH (ptw_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ptw_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign ent_present = ram_rdata[ptw_pkg::ENTRY_PRESENT_BIT];
    assign ent_num     = ram_rdata[ptw_pkg::ENTRY_W-1:2];
    assign num_ok      = ent_num < ptw_pkg::FRAME_W'(TABLE_COUNT);
    assign pool_empty  = free_reg >= NW'(TABLE_COUNT);

    always_comb
    begin
        case (lvl_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    // the walk ends at this evaluation: leaf level, an intermediate miss, or a bad table number
    always_comb
    begin
        if (lvl_reg == ptw_pkg::LEVEL_LEAF)
        begin
            walk_stop = 1'b1;
        end
        else if (ent_present)
        begin
            walk_stop = !num_ok;
        end
        else
        begin
            walk_stop = (cmd_reg != ptw_pkg::CMD_MAP) || pool_empty;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptw_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ptw_pkg::ST_IDLE;
                end
            end
            ptw_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tdata[1:0] inside {ptw_pkg::CMD_MAP, ptw_pkg::CMD_UNMAP,
                                             ptw_pkg::CMD_TRANSLATE})
                    begin
                        state_next = ptw_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = ptw_pkg::ST_DONE;
                    end
                end
            end
            ptw_pkg::ST_READ:
            begin
                state_next = ptw_pkg::ST_EVAL;
            end
            ptw_pkg::ST_EVAL:
            begin
                state_next = walk_stop ? ptw_pkg::ST_DONE : ptw_pkg::ST_READ;
            end
            ptw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ptw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_next        = clr_reg;
        lvl_next        = lvl_reg;
        table_next      = table_reg;
        free_next       = free_reg;
        cmd_next        = cmd_reg;
        va_next         = va_reg;
        frame_next      = frame_reg;
        wr_next         = wr_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        res_lw_next     = res_lw_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = {table_reg, idx};
        ram_wdata       = '0;

        case (state_reg)
            ptw_pkg::ST_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + AW'(1);
            end
            ptw_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next        = s_tdata[1:0];
                    va_next         = s_tdata[49:2];
                    frame_next      = s_tdata[101:62];
                    wr_next         = s_tdata[102];
                    lvl_next        = 2'd0;
                    table_next      = '0;
                    res_addr_next   = '0;
                    res_status_next = ptw_pkg::STATUS_OK;
                    res_lw_next     = 1'b0;
                end
            end
            ptw_pkg::ST_READ:
            begin
                ram_en = 1'b1;
            end
            ptw_pkg::ST_EVAL:
            begin
                if (lvl_reg != ptw_pkg::LEVEL_LEAF)
                begin
                    lvl_next = lvl_reg + 2'd1;
                    if (ent_present)
                    begin
                        table_next = ent_num[TW-1:0];
                        if (!num_ok)
                        begin
                            res_status_next = ptw_pkg::STATUS_NOT_MAPPED;
                        end
                    end
                    else if (cmd_reg != ptw_pkg::CMD_MAP)
                    begin
                        res_status_next = ptw_pkg::STATUS_NOT_MAPPED;
                    end
                    else if (pool_empty)
                    begin
                        res_status_next = ptw_pkg::STATUS_NO_TABLES;
                    end
                    else
                    begin
                        // link a fresh table from the pool
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        ram_wdata  = {ptw_pkg::FRAME_W'(free_reg), 2'b11};
                        table_next = free_reg[TW-1:0];
                        free_next  = free_reg + NW'(1);
                    end
                end
                else
                begin
                    case (cmd_reg)
                        ptw_pkg::CMD_MAP:
                        begin
                            if (ent_present)
                            begin
                                res_status_next = ptw_pkg::STATUS_ALREADY;
                            end
                            else
                            begin
                                ram_en    = 1'b1;
                                ram_we    = 1'b1;
                                ram_wdata = {frame_reg, wr_reg, 1'b1};
                            end
                        end
                        ptw_pkg::CMD_UNMAP:
                        begin
                            ram_en = 1'b1;
                            ram_we = 1'b1;
                            if (!ent_present)
                            begin
                                res_status_next = ptw_pkg::STATUS_NOT_MAPPED;
                            end
                        end
                        default:
                        begin
                            if (ent_present)
                            begin
                                res_addr_next = {ent_num, va_reg[ptw_pkg::OFFSET_W-1:0]};
                                res_lw_next   = ram_rdata[ptw_pkg::ENTRY_WRITABLE_BIT];
                            end
                            else
                            begin
                                res_status_next = ptw_pkg::STATUS_NOT_MAPPED;
                            end
                        end
                    endcase
                end
            end
            ptw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, res_lw_reg, res_status_reg, res_addr_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ptw_pkg::ST_CLEAR;
            clr_reg     <= '0;
            lvl_reg     <= '0;
            table_reg   <= '0;
            free_reg    <= NW'(1);
            cmd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            lvl_reg     <= lvl_next;
            table_reg   <= table_next;
            free_reg    <= free_next;
            cmd_reg     <= cmd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg         <= va_next;
        frame_reg      <= frame_next;
        wr_reg         <= wr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        res_lw_reg     <= res_lw_next;
        m_data_reg     <= m_data_next;
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptw_pkg::ST_IDLE || state_reg == ptw_pkg::ST_DONE) |-> !ram_we)
        else $error("table store written outside a walk or clear");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg <= NW'(TABLE_COUNT)) && (free_reg != '0))
        else $error("free table pointer out of range");

    a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptw_pkg::ST_READ) |-> (NW'(table_reg) < free_reg))
        else $error("walk reads a table not yet allocated");

    a_pool_grows_on_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ptw_pkg::ST_EVAL || cmd_reg != ptw_pkg::CMD_MAP) |=> $stable(free_reg))
        else $error("pool changed outside a map walk");

endmodule

// ===== design/ptw_ram.sv =====
module ptw_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule
